// File: rtl/tpr_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes and the queue entry type for the triangle point mapper.
// Used by every module under rtl; depends on nothing.
package tpr_pkg;

  localparam int COORD_W    = 32;              // Q16.16 coordinate
  localparam int DIFF_W     = COORD_W + 1;     // edge and offset differences
  localparam int PROD_W     = 2 * DIFF_W;      // signed products and 2x2 determinants
  localparam int MAG_W      = PROD_W - 1;      // magnitude of a determinant (below 2^65)
  localparam int FRAC_W     = 16;
  localparam int QBITS      = 2 * FRAC_W + 1;  // quotient bits kept before saturation
  localparam int QR_W       = QBITS + 1;       // quotient after rounding
  localparam int EPS_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_PIVOT_EPS = 1'b0;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic signed [PROD_W-1:0] det;
    logic signed [PROD_W-1:0] num0;
    logic signed [PROD_W-1:0] num1;
    logic                     piv_small;
  } solve_t;

endpackage

// File: rtl/tpr_front.sv
`timescale 1ns / 1ps
// Front part: edge differences, products, pivot test and Cramer numerators in three stages.
// Depends on tpr_pkg.
module tpr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex0_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex0_y_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex1_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex1_y_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex2_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex2_y_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  point_y_i,
  input  logic [tpr_pkg::EPS_W-1:0]           pivot_eps_i,
  input  logic                                ent_full_i,
  output logic                                ent_valid_o,
  output tpr_pkg::solve_t                     ent_o
);

  logic adv;
  logic v1_q, v2_q, v3_q;
  logic signed [tpr_pkg::DIFF_W-1:0] a00_q, a10_q, a01_q, a11_q, b0_q, b1_q;
  logic signed [tpr_pkg::PROD_W-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [tpr_pkg::PROD_W-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [tpr_pkg::DIFF_W-1:0] m0, m1, pivot;
  logic piv_small_q2, piv_small_q3;
  logic signed [tpr_pkg::PROD_W-1:0] det_q, num0_q, num1_q;

  assign adv        = !(v3_q && ent_full_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a00_q <= tpr_pkg::DIFF_W'(vertex1_x_i) - tpr_pkg::DIFF_W'(vertex0_x_i);
      a10_q <= tpr_pkg::DIFF_W'(vertex1_y_i) - tpr_pkg::DIFF_W'(vertex0_y_i);
      a01_q <= tpr_pkg::DIFF_W'(vertex2_x_i) - tpr_pkg::DIFF_W'(vertex0_x_i);
      a11_q <= tpr_pkg::DIFF_W'(vertex2_y_i) - tpr_pkg::DIFF_W'(vertex0_y_i);
      b0_q  <= tpr_pkg::DIFF_W'(point_x_i) - tpr_pkg::DIFF_W'(vertex0_x_i);
      b1_q  <= tpr_pkg::DIFF_W'(point_y_i) - tpr_pkg::DIFF_W'(vertex0_y_i);
    end
  end

  // Row pivoting only picks the larger first-column entry; the solution itself is exact,
  // so the pivot matters just for the epsilon test.
  assign m0    = a00_q[tpr_pkg::DIFF_W-1] ? tpr_pkg::DIFF_W'(-a00_q) : tpr_pkg::DIFF_W'(a00_q);
  assign m1    = a10_q[tpr_pkg::DIFF_W-1] ? tpr_pkg::DIFF_W'(-a10_q) : tpr_pkg::DIFF_W'(a10_q);
  assign pivot = (m0 < m1) ? m1 : m0;

  assign p0 = a00_q * a11_q;
  assign p1 = a01_q * a10_q;
  assign p2 = a11_q * b0_q;
  assign p3 = a01_q * b1_q;
  assign p4 = a00_q * b1_q;
  assign p5 = a10_q * b0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q         <= p0;
      p1_q         <= p1;
      p2_q         <= p2;
      p3_q         <= p3;
      p4_q         <= p4;
      p5_q         <= p5;
      piv_small_q2 <= pivot < tpr_pkg::DIFF_W'(pivot_eps_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q        <= p0_q - p1_q;
      num0_q       <= p2_q - p3_q;
      num1_q       <= p4_q - p5_q;
      piv_small_q3 <= piv_small_q2;
    end
  end

  assign ent_valid_o     = v3_q;
  assign ent_o.det       = det_q;
  assign ent_o.num0      = num0_q;
  assign ent_o.num1      = num1_q;
  assign ent_o.piv_small = piv_small_q3;

endmodule

// File: rtl/tpr_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and the back part.
// Depends on tpr_pkg.
module tpr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tpr_pkg::solve_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output tpr_pkg::solve_t data_o
);

  tpr_pkg::solve_t mem_q [tpr_pkg::FIFO_DEPTH];
  logic [tpr_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [tpr_pkg::FIFO_AW:0]   cnt_q;

  assign full_o  = cnt_q == (tpr_pkg::FIFO_AW+1)'(tpr_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (tpr_pkg::FIFO_AW+1)'(push_i) - (tpr_pkg::FIFO_AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (tpr_pkg::FIFO_AW+1)'(tpr_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: rtl/tpr_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage of (num << 16) / den.
// Depends on tpr_pkg.
module tpr_divider (
  input  logic                         clk_i,
  input  logic                         adv_i,
  input  logic [tpr_pkg::MAG_W-1:0]    num_i,
  input  logic [tpr_pkg::MAG_W-1:0]    den_i,
  output logic [tpr_pkg::QBITS-1:0]    quo_o,
  output logic [tpr_pkg::MAG_W-1:0]    rem_o,
  output logic [tpr_pkg::MAG_W-1:0]    den_o,
  output logic                         ovf_o
);

  localparam int QB = tpr_pkg::QBITS;
  localparam int MW = tpr_pkg::MAG_W;
  localparam int FW = tpr_pkg::FRAC_W;

  logic [MW-1:0] rem_q [QB+1];
  logic [MW-1:0] den_q [QB+1];
  logic [QB-1:0] low_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];

  // The quotient needs more than QBITS bits exactly when the high part of the shifted
  // numerator already reaches the divisor; that case saturates anyway.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= MW'(num_i[MW-1:FW+1]);
      low_q[0] <= {num_i[FW:0], FW'(0)};
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= MW'(num_i[MW-1:FW+1]) >= den_i;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;
    assign trial = {rem_q[j-1], low_q[j-1][QB-1]};
    assign diff  = trial - {1'b0, den_q[j-1]};
    assign ge    = trial >= {1'b0, den_q[j-1]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[j] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        low_q[j] <= {low_q[j-1][QB-2:0], 1'b0};
        den_q[j] <= den_q[j-1];
        quo_q[j] <= {quo_q[j-1][QB-2:0], ge};
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign rem_o = rem_q[QB];
  assign den_o = den_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

// File: rtl/tpr_back.sv
`timescale 1ns / 1ps
// Back part: magnitudes and singular test, two divider lanes, rounding, saturation, result.
// Depends on tpr_pkg and tpr_divider.
module tpr_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                ent_valid_i,
  input  tpr_pkg::solve_t                     ent_i,
  output logic                                ent_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tpr_pkg::COORD_W-1:0]  ref_x_o,
  output logic signed [tpr_pkg::COORD_W-1:0]  ref_y_o,
  output logic                                singular_o,
  output logic                                saturated_o
);

  localparam int QB = tpr_pkg::QBITS;
  localparam int MW = tpr_pkg::MAG_W;
  localparam int RW = tpr_pkg::QR_W;
  localparam int CW = tpr_pkg::COORD_W;

  typedef struct packed {
    logic valid;
    logic neg0;
    logic neg1;
    logic sing;
  } side_t;

  logic adv;
  side_t side_in, side_r_q;
  side_t side_q [QB+2];
  logic [MW-1:0] n0m_q, n1m_q, dm_q;
  logic [QB-1:0] quo0, quo1;
  logic [MW-1:0] rem0, rem1, den0, den1;
  logic ovf0, ovf1;
  logic [RW-1:0] qr0_q, qr1_q;
  logic ovf0_q, ovf1_q;
  logic [RW-1:0] lim0, lim1;
  logic sat0, sat1;
  logic out_valid_q, sing_q, sat_q;
  logic signed [CW-1:0] rx_q, ry_q;

  assign adv       = !out_valid_q || !out_stall_i;
  assign ent_pop_o = adv && ent_valid_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n0m_q <= ent_i.num0[MW] ? MW'(-ent_i.num0) : ent_i.num0[MW-1:0];
      n1m_q <= ent_i.num1[MW] ? MW'(-ent_i.num1) : ent_i.num1[MW-1:0];
      dm_q  <= ent_i.det[MW]  ? MW'(-ent_i.det)  : ent_i.det[MW-1:0];
    end
  end

  assign side_in = '{valid: ent_valid_i,
                     neg0:  ent_i.num0[MW] != ent_i.det[MW],
                     neg1:  ent_i.num1[MW] != ent_i.det[MW],
                     sing:  ent_i.piv_small || (ent_i.det == '0)};

  // Side information rides along the divider stages so the lanes need no tags.
  // It lines up with the rounded quotients when it reaches side_r_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB + 1; k++) side_q[k] <= '0;
      side_r_q <= '0;
    end else if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k <= QB + 1; k++) side_q[k] <= side_q[k-1];
      side_r_q <= side_q[QB+1];
    end
  end

  tpr_divider u_div0 (
    .clk_i (clk_i), .adv_i (adv), .num_i (n0m_q), .den_i (dm_q),
    .quo_o (quo0), .rem_o (rem0), .den_o (den0), .ovf_o (ovf0)
  );

  tpr_divider u_div1 (
    .clk_i (clk_i), .adv_i (adv), .num_i (n1m_q), .den_i (dm_q),
    .quo_o (quo1), .rem_o (rem1), .den_o (den1), .ovf_o (ovf1)
  );

  // Round half away from zero on the magnitude.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      qr0_q  <= RW'(quo0) + RW'({rem0, 1'b0} >= {1'b0, den0});
      qr1_q  <= RW'(quo1) + RW'({rem1, 1'b0} >= {1'b0, den1});
      ovf0_q <= ovf0;
      ovf1_q <= ovf1;
    end
  end

  assign lim0 = side_r_q.neg0 ? RW'(33'h0_8000_0000) : RW'(33'h0_7fff_ffff);
  assign lim1 = side_r_q.neg1 ? RW'(33'h0_8000_0000) : RW'(33'h0_7fff_ffff);
  assign sat0 = ovf0_q || (qr0_q > lim0);
  assign sat1 = ovf1_q || (qr1_q > lim1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_r_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sing_q <= side_r_q.sing;
      sat_q  <= !side_r_q.sing && (sat0 || sat1);
      if (side_r_q.sing) begin
        rx_q <= '0;
        ry_q <= '0;
      end else begin
        rx_q <= sat0 ? (side_r_q.neg0 ? CW'(32'h8000_0000) : CW'(32'h7fff_ffff))
                     : (side_r_q.neg0 ? CW'(-qr0_q) : CW'(qr0_q));
        ry_q <= sat1 ? (side_r_q.neg1 ? CW'(32'h8000_0000) : CW'(32'h7fff_ffff))
                     : (side_r_q.neg1 ? CW'(-qr1_q) : CW'(qr1_q));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign ref_x_o     = rx_q;
  assign ref_y_o     = ry_q;
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

endmodule

// File: rtl/triangle_point_to_reference_top.sv
`timescale 1ns / 1ps
// Top level of the triangle point mapper: configuration port, front, queue and back.
// Depends on tpr_pkg, tpr_front, tpr_fifo and tpr_back.

// Each input beat carries a triangle (three vertices) and a point, all signed Q16.16,
// and yields exactly one result beat with the point's reference coordinates, rounded to
// nearest (ties away from zero) and clamped to Q16.16. The block takes one beat per clock
// cycle and delivers one per cycle when nothing stalls it; results leave in input order.
// An item passes 41 registers: three front stages (differences, 33x33 products with the
// pivot test, determinant and numerators), one entry of a four-entry queue, then the back
// part with a magnitude stage, the two restoring divider lanes (an overflow check stage
// plus 33 stages of one quotient bit each), a rounding stage and the output register.
// The queue lets the front keep accepting beats for a while when the result side stalls.
// A matrix whose larger first-column entry is below pivot_epsilon, or whose determinant is
// zero, gives zero coordinates with singular set. pivot_epsilon sits at byte address 0 of
// the configuration port (reset value 1) and should only be written while the block is idle.
module triangle_point_to_reference_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpr_pkg::ADDR_W-1:0]          paddr,
  input  logic [tpr_pkg::DATA_W-1:0]          pwdata,
  output logic [tpr_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex0_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex0_y_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex1_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex1_y_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex2_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  vertex2_y_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [tpr_pkg::COORD_W-1:0]  point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tpr_pkg::COORD_W-1:0]  ref_x_o,
  output logic signed [tpr_pkg::COORD_W-1:0]  ref_y_o,
  output logic                                singular_o,
  output logic                                saturated_o
);

  logic [tpr_pkg::EPS_W-1:0] eps_q;
  tpr_pkg::reg_idx_t         reg_idx;
  logic                      cfg_wr;
  logic                      ent_valid, ent_full, q_empty, q_pop;
  tpr_pkg::solve_t           ent_front, ent_back;

  // Registers sit on 4-byte boundaries; the word index is the address above bit 1.
  assign reg_idx = paddr[tpr_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= tpr_pkg::EPS_W'(1);
    end else if (cfg_wr && (reg_idx == tpr_pkg::REG_PIVOT_EPS)) begin
      eps_q <= pwdata[tpr_pkg::EPS_W-1:0];
    end
  end

  assign prdata = (reg_idx == tpr_pkg::REG_PIVOT_EPS) ? tpr_pkg::DATA_W'(eps_q) : '0;

  tpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vertex0_x_i (vertex0_x_i),
    .vertex0_y_i (vertex0_y_i),
    .vertex1_x_i (vertex1_x_i),
    .vertex1_y_i (vertex1_y_i),
    .vertex2_x_i (vertex2_x_i),
    .vertex2_y_i (vertex2_y_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .pivot_eps_i (eps_q),
    .ent_full_i  (ent_full),
    .ent_valid_o (ent_valid),
    .ent_o       (ent_front)
  );

  // The front pushes whenever its last stage holds an item and the queue has room.
  tpr_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_valid && !ent_full),
    .data_i  (ent_front),
    .full_o  (ent_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (ent_back)
  );

  tpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (!q_empty),
    .ent_i       (ent_back),
    .ent_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ref_x_o     (ref_x_o),
    .ref_y_o     (ref_y_o),
    .singular_o  (singular_o),
    .saturated_o (saturated_o)
  );

  // A singular result always carries zero coordinates and no clamp flag.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> ref_x_o == '0 && ref_y_o == '0 && !saturated_o)
    else $error("singular result with nonzero payload");

  // A clamped result shows at least one coordinate at a range limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      ref_x_o == 32'sh7fff_ffff || ref_x_o == 32'sh8000_0000 ||
      ref_y_o == 32'sh7fff_ffff || ref_y_o == 32'sh8000_0000)
    else $error("saturated result without a clamped coordinate");

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ref_x_o) && $stable(ref_y_o) &&
      $stable(singular_o) && $stable(saturated_o))
    else $error("stalled result beat changed");

endmodule
